// ----- rtl/dms_pkg.sv -----
// Shared types, codes and reset constants of the door motor sequencer.
`timescale 1ns / 1ps
`default_nettype none

package dms_pkg;

    localparam int TIME_W  = 16;
    localparam int DUTY_W  = 8;
    localparam int REQ_W   = 2;
    localparam int PHASE_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [TIME_W-1:0] OPEN_TIME_RST  = 16'd2000;
    localparam logic [TIME_W-1:0] HOLD_TIME_RST  = 16'd5000;
    localparam logic [TIME_W-1:0] CLOSE_TIME_RST = 16'd2000;
    localparam logic [DUTY_W-1:0] DRIVE_DUTY_RST = 8'd255;
    localparam logic [TIME_W-1:0] ELAPSED_MAX    = {TIME_W{1'b1}};

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE    = 2'd0,
        PH_OPENING = 2'd1,
        PH_HOLDING = 2'd2,
        PH_CLOSING = 2'd3
    } phase_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_TICK  = 2'd0,
        REQ_OPEN  = 2'd1,
        REQ_CLOSE = 2'd2,
        REQ_MODE  = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OPEN_TIME  = 2'd0,
        CFG_HOLD_TIME  = 2'd1,
        CFG_CLOSE_TIME = 2'd2,
        CFG_DRIVE_DUTY = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [TIME_W-1:0] open_time_ms;
        logic [TIME_W-1:0] hold_time_ms;
        logic [TIME_W-1:0] close_time_ms;
        logic [DUTY_W-1:0] drive_duty;
    } cfg_t;

    typedef struct packed {
        phase_t            phase;
        logic [TIME_W-1:0] elapsed_ms;
        logic              free_access;
    } seq_state_t;

    typedef struct packed {
        logic [DUTY_W-1:0]  bridge_in1;
        logic [DUTY_W-1:0]  bridge_in2;
        logic [PHASE_W-1:0] door_phase;
        logic               free_access_on;
    } seq_result_t;

endpackage

`default_nettype wire

// ----- rtl/dms_if.sv -----
// Request and result channel interfaces of the door motor sequencer.
`timescale 1ns / 1ps
`default_nettype none

interface dms_req_if;
    logic                      valid;
    logic                      ready;
    logic [dms_pkg::REQ_W-1:0] req_type;
    logic                      mode_enable;

    modport source (output valid, output req_type, output mode_enable, input ready);
    modport sink   (input valid, input req_type, input mode_enable, output ready);
endinterface

interface dms_res_if;
    logic                        valid;
    logic                        ready;
    logic [dms_pkg::DUTY_W-1:0]  bridge_in1;
    logic [dms_pkg::DUTY_W-1:0]  bridge_in2;
    logic [dms_pkg::PHASE_W-1:0] door_phase;
    logic                        free_access_on;

    modport source (output valid, output bridge_in1, output bridge_in2,
                    output door_phase, output free_access_on, input ready);
    modport sink   (input valid, input bridge_in1, input bridge_in2,
                    input door_phase, input free_access_on, output ready);
endinterface

`default_nettype wire

// ----- rtl/door_motor_sequencer_core.sv -----
// Door motor sequencer: request register, phase update and result register.
//
// Usage:
//   req_ch carries one request per transaction: req_type (tick, open, close,
//   set free-access mode) and mode_enable. res_ch returns exactly one result
//   per request: the two bridge drive levels, the door phase and the
//   free-access flag as they stand after that request.
//   Configuration is written through cfg_we / cfg_index / cfg_wdata at any
//   edge with cfg_we high; write only while no request is in flight.
// Path: a taken request waits in the request register until the result
//   register is free; its result is then loaded there and shown on res_ch.
// Throughput: one request per cycle while res_ch is ready; the phase and
//   elapsed registers are updated in the same cycle as the result register.
// Reset: phase idle, elapsed count zero, free access off, both channels
//   empty, registers at their default times and full duty.
// Stall: when res_ch is not ready the result holds; one more request may
//   still be taken into the request register, after which req_ch.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module door_motor_sequencer_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    dms_req_if.sink                             req_ch,
    dms_res_if.source                           res_ch,
    input  wire logic                           cfg_we,
    input  wire logic [dms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dms_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    logic                      in_valid_reg;
    logic [dms_pkg::REQ_W-1:0] req_type_reg;
    logic                      mode_enable_reg;

    dms_pkg::seq_state_t  state_reg;
    dms_pkg::seq_state_t  state_next;
    dms_pkg::cfg_t        cfg_reg;
    dms_pkg::seq_result_t res_next;
    dms_pkg::seq_result_t res_reg;
    logic                 out_valid_reg;
    logic                 advance;

    assign advance      = in_valid_reg && (!out_valid_reg || res_ch.ready);
    assign req_ch.ready = !in_valid_reg || advance;

    // Request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req_ch.ready)
            in_valid_reg <= req_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_ch.ready && req_ch.valid)
        begin
            req_type_reg    <= req_ch.req_type;
            mode_enable_reg <= req_ch.mode_enable;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.open_time_ms  <= dms_pkg::OPEN_TIME_RST;
            cfg_reg.hold_time_ms  <= dms_pkg::HOLD_TIME_RST;
            cfg_reg.close_time_ms <= dms_pkg::CLOSE_TIME_RST;
            cfg_reg.drive_duty    <= dms_pkg::DRIVE_DUTY_RST;
        end
        else if (cfg_we)
        begin
            case (dms_pkg::cfg_idx_t'(cfg_index))
                dms_pkg::CFG_OPEN_TIME:  cfg_reg.open_time_ms  <= cfg_wdata;
                dms_pkg::CFG_HOLD_TIME:  cfg_reg.hold_time_ms  <= cfg_wdata;
                dms_pkg::CFG_CLOSE_TIME: cfg_reg.close_time_ms <= cfg_wdata;
                dms_pkg::CFG_DRIVE_DUTY:
                    cfg_reg.drive_duty <= cfg_wdata[dms_pkg::DUTY_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    dms_step u_step (
        .req_type    (req_type_reg),
        .mode_enable (mode_enable_reg),
        .cur         (state_reg),
        .cfg         (cfg_reg),
        .nxt         (state_next),
        .res         (res_next)
    );

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= dms_pkg::PH_IDLE;
            state_reg.elapsed_ms  <= '0;
            state_reg.free_access <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (res_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign res_ch.valid          = out_valid_reg;
    assign res_ch.bridge_in1     = res_reg.bridge_in1;
    assign res_ch.bridge_in2     = res_reg.bridge_in2;
    assign res_ch.door_phase     = res_reg.door_phase;
    assign res_ch.free_access_on = res_reg.free_access_on;

endmodule

`default_nettype wire

// ----- rtl/dms_step.sv -----
// Phase and elapsed-time update for one request, with the drive levels it yields.
`timescale 1ns / 1ps
`default_nettype none

module dms_step (
    input  wire logic [dms_pkg::REQ_W-1:0] req_type,
    input  wire logic                      mode_enable,
    input  wire dms_pkg::seq_state_t       cur,
    input  wire dms_pkg::cfg_t             cfg,
    output dms_pkg::seq_state_t            nxt,
    output dms_pkg::seq_result_t           res
);

    logic [dms_pkg::TIME_W-1:0] elapsed_inc;
    logic                       may_open;
    logic                       may_close;

    // Saturating millisecond count
    assign elapsed_inc = (cur.elapsed_ms == dms_pkg::ELAPSED_MAX) ?
                         cur.elapsed_ms : cur.elapsed_ms + 1'b1;
    assign may_open  = (cur.phase == dms_pkg::PH_IDLE) || (cur.phase == dms_pkg::PH_CLOSING);
    assign may_close = !cur.free_access &&
                       ((cur.phase == dms_pkg::PH_OPENING) ||
                        (cur.phase == dms_pkg::PH_HOLDING));

    // Next state
    always_comb
    begin
        nxt = cur;
        case (dms_pkg::req_t'(req_type))
            dms_pkg::REQ_TICK:
            begin
                nxt.elapsed_ms = elapsed_inc;
                case (cur.phase)
                    dms_pkg::PH_OPENING:
                    begin
                        if (elapsed_inc >= cfg.open_time_ms)
                        begin
                            nxt.phase      = dms_pkg::PH_HOLDING;
                            nxt.elapsed_ms = '0;
                        end
                    end
                    dms_pkg::PH_HOLDING:
                    begin
                        if (!cur.free_access && (elapsed_inc >= cfg.hold_time_ms))
                        begin
                            nxt.phase      = dms_pkg::PH_CLOSING;
                            nxt.elapsed_ms = '0;
                        end
                    end
                    dms_pkg::PH_CLOSING:
                    begin
                        // leave the count running into idle
                        if (elapsed_inc >= cfg.close_time_ms)
                            nxt.phase = dms_pkg::PH_IDLE;
                    end
                    default:
                    begin
                        nxt.phase = cur.phase;
                    end
                endcase
            end
            dms_pkg::REQ_OPEN:
            begin
                if (may_open)
                begin
                    nxt.phase      = dms_pkg::PH_OPENING;
                    nxt.elapsed_ms = '0;
                end
            end
            dms_pkg::REQ_CLOSE:
            begin
                if (may_close)
                begin
                    nxt.phase      = dms_pkg::PH_CLOSING;
                    nxt.elapsed_ms = '0;
                end
            end
            dms_pkg::REQ_MODE:
            begin
                nxt.free_access = mode_enable;
                if (mode_enable)
                begin
                    if (may_open)
                    begin
                        nxt.phase      = dms_pkg::PH_OPENING;
                        nxt.elapsed_ms = '0;
                    end
                end
                else if (cur.phase == dms_pkg::PH_HOLDING)
                begin
                    // force a close on the next tick
                    nxt.elapsed_ms = cfg.hold_time_ms;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        res.bridge_in1     = (nxt.phase == dms_pkg::PH_CLOSING) ? cfg.drive_duty : '0;
        res.bridge_in2     = (nxt.phase == dms_pkg::PH_OPENING) ? cfg.drive_duty : '0;
        res.door_phase     = nxt.phase;
        res.free_access_on = nxt.free_access;
    end

endmodule

`default_nettype wire

// ----- rtl/dms_checker.sv -----
// Port-level assertions of the door motor sequencer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dms_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [dms_pkg::DUTY_W-1:0]  bridge_in1,
    input wire logic [dms_pkg::DUTY_W-1:0]  bridge_in2,
    input wire logic [dms_pkg::PHASE_W-1:0] door_phase,
    input wire logic                        free_access_on
);

    // Forward drive only while opening
    a_in2_opening: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (bridge_in2 != '0)) |-> (door_phase == dms_pkg::PH_OPENING))
        else $error("bridge_in2 driven outside opening");

    // Reverse drive only while closing
    a_in1_closing: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (bridge_in1 != '0)) |-> (door_phase == dms_pkg::PH_CLOSING))
        else $error("bridge_in1 driven outside closing");

    // Free access can never coexist with a closing door
    a_free_no_close: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && free_access_on) |-> (door_phase != dms_pkg::PH_CLOSING))
        else $error("closing while free access is on");

    // Stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
        (out_valid && $stable(bridge_in1) && $stable(bridge_in2) &&
         $stable(door_phase) && $stable(free_access_on)))
        else $error("result changed while stalled");

endmodule

bind door_motor_sequencer_core dms_checker u_dms_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (res_ch.valid),
    .out_ready      (res_ch.ready),
    .bridge_in1     (res_ch.bridge_in1),
    .bridge_in2     (res_ch.bridge_in2),
    .door_phase     (res_ch.door_phase),
    .free_access_on (res_ch.free_access_on)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench of the door motor sequencer core.
`timescale 1ns / 1ps

module tb_top;
    import dms_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_OFF    = 200;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    dms_req_if req_if();
    dms_res_if res_if();

    door_motor_sequencer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_ch    (req_if),
        .res_ch    (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Predicted door state and register copy
    cfg_t              door_cfg;
    phase_t            door_phase_q;
    logic [TIME_W-1:0] elapsed_q;
    logic              free_access_q;
    seq_result_t       door_results[$];

    int unsigned error_count;
    int unsigned quiet_cycles;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_off_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void start_opening();
        if (door_phase_q == PH_IDLE || door_phase_q == PH_CLOSING)
        begin
            door_phase_q = PH_OPENING;
            elapsed_q    = '0;
        end
    endfunction

    function automatic seq_result_t step_door(req_t kind, logic en);
        seq_result_t res;
        case (kind)
            REQ_TICK:
            begin
                if (elapsed_q != ELAPSED_MAX)
                    elapsed_q = elapsed_q + 1'b1;
                case (door_phase_q)
                    PH_OPENING:
                        if (elapsed_q >= door_cfg.open_time_ms)
                        begin
                            door_phase_q = PH_HOLDING;
                            elapsed_q    = '0;
                        end
                    PH_HOLDING:
                        if (!free_access_q && elapsed_q >= door_cfg.hold_time_ms)
                        begin
                            door_phase_q = PH_CLOSING;
                            elapsed_q    = '0;
                        end
                    PH_CLOSING:
                        // elapsed count keeps running into idle
                        if (elapsed_q >= door_cfg.close_time_ms)
                            door_phase_q = PH_IDLE;
                    default: ;
                endcase
            end
            REQ_OPEN:
                start_opening();
            REQ_CLOSE:
                if (!free_access_q &&
                    (door_phase_q == PH_OPENING || door_phase_q == PH_HOLDING))
                begin
                    door_phase_q = PH_CLOSING;
                    elapsed_q    = '0;
                end
            default:
            begin
                free_access_q = en;
                if (en)
                    start_opening();
                else if (door_phase_q == PH_HOLDING)
                    elapsed_q = door_cfg.hold_time_ms;  // close on the next tick
            end
        endcase
        res.bridge_in1     = (door_phase_q == PH_CLOSING) ? door_cfg.drive_duty : '0;
        res.bridge_in2     = (door_phase_q == PH_OPENING) ? door_cfg.drive_duty : '0;
        res.door_phase     = door_phase_q;
        res.free_access_on = free_access_q;
        return res;
    endfunction

    task automatic flag_error(string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic check_result();
        seq_result_t want;
        if (door_results.size() == 0)
        begin
            flag_error($sformatf("result with nothing pending (phase %0d)",
                                 res_if.door_phase));
            return;
        end
        want = door_results.pop_front();
        if (res_if.bridge_in1 !== want.bridge_in1)
            flag_error($sformatf("bridge_in1 expected %0d, got %0d",
                                 want.bridge_in1, res_if.bridge_in1));
        if (res_if.bridge_in2 !== want.bridge_in2)
            flag_error($sformatf("bridge_in2 expected %0d, got %0d",
                                 want.bridge_in2, res_if.bridge_in2));
        if (res_if.door_phase !== want.door_phase)
            flag_error($sformatf("door_phase expected %0d, got %0d",
                                 want.door_phase, res_if.door_phase));
        if (res_if.free_access_on !== want.free_access_on)
            flag_error($sformatf("free_access_on expected %0d, got %0d",
                                 want.free_access_on, res_if.free_access_on));
    endtask

    // Track accepted transactions and register writes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
                check_result();
            if (req_if.valid && req_if.ready)
                door_results.push_back(step_door(req_t'(req_if.req_type),
                                                 req_if.mode_enable));
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_OPEN_TIME:  door_cfg.open_time_ms  = cfg_wdata;
                    CFG_HOLD_TIME:  door_cfg.hold_time_ms  = cfg_wdata;
                    CFG_CLOSE_TIME: door_cfg.close_time_ms = cfg_wdata;
                    CFG_DRIVE_DUTY: door_cfg.drive_duty    = cfg_wdata[DUTY_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: random stalls, or a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            res_if.ready  <= 1'b0;
            hold_off_left <= hold_off_left - 1;
        end
        else
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_request(req_t kind, logic en);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.req_type    <= kind;
        req_if.mode_enable <= en;
        do
            @(posedge clk);
        while (!req_if.ready);
        @(negedge clk);
    endtask

    task automatic drain_requests();
        req_if.valid <= 1'b0;
        while (door_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
    endtask

    task automatic write_regs(logic [CFG_DATA_W-1:0] open_t, logic [CFG_DATA_W-1:0] hold_t,
                              logic [CFG_DATA_W-1:0] close_t, logic [CFG_DATA_W-1:0] duty);
        drain_requests();
        write_reg(CFG_OPEN_TIME, open_t);
        write_reg(CFG_HOLD_TIME, hold_t);
        write_reg(CFG_CLOSE_TIME, close_t);
        write_reg(CFG_DRIVE_DUTY, duty);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] short_time();
        if ($urandom_range(9) == 0)
            return CFG_DATA_W'($urandom);
        return CFG_DATA_W'($urandom_range(12));
    endfunction

    task automatic test_reset_defaults();
        send_request(REQ_TICK, 1'b1);
        send_request(REQ_OPEN, 1'b0);
        send_request(REQ_TICK, 1'b0);
        send_request(REQ_CLOSE, 1'b1);
        send_request(REQ_CLOSE, 1'b0);
        send_request(REQ_OPEN, 1'b1);   // reverse from closing
        send_request(REQ_OPEN, 1'b0);
    endtask

    task automatic test_zero_times();
        write_regs('0, '0, '0, '0);
        send_request(REQ_TICK, 1'b0);
        send_request(REQ_OPEN, 1'b0);
        send_request(REQ_TICK, 1'b0);
        send_request(REQ_TICK, 1'b0);
        send_request(REQ_TICK, 1'b0);
        send_request(REQ_CLOSE, 1'b0);
    endtask

    task automatic test_free_access();
        write_regs(16'd1, 16'd2, 16'd1, 16'h5AA5);
        send_request(REQ_MODE, 1'b1);
        send_request(REQ_TICK, 1'b0);
        send_request(REQ_TICK, 1'b0);
        send_request(REQ_TICK, 1'b0);
        send_request(REQ_TICK, 1'b0);
        send_request(REQ_CLOSE, 1'b0);
        send_request(REQ_OPEN, 1'b0);
        send_request(REQ_MODE, 1'b0);   // forced close on next tick
        send_request(REQ_TICK, 1'b1);
        send_request(REQ_MODE, 1'b0);
        send_request(REQ_MODE, 1'b1);
        send_request(REQ_MODE, 1'b0);
        send_request(REQ_CLOSE, 1'b0);
    endtask

    task automatic test_random_traffic(int unsigned count, int unsigned send_pct,
                                       int unsigned recv_pct);
        int unsigned pick;
        req_t        kind;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                kind = REQ_TICK;
            else if (pick < 72)
                kind = REQ_OPEN;
            else if (pick < 88)
                kind = REQ_CLOSE;
            else
                kind = REQ_MODE;
            send_request(kind, 1'($urandom_range(1)));
        end
    endtask

    task automatic test_backpressure();
        drain_requests();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge clk);
        hold_off_left = HOLD_OFF;
        @(negedge clk);
        // keep offering while results are held back
        repeat (12)
            send_request(req_t'($urandom_range(3)), 1'($urandom_range(1)));
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_wdata          = '0;
        req_if.valid       = 1'b0;
        req_if.req_type    = REQ_TICK;
        req_if.mode_enable = 1'b0;
        res_if.ready       = 1'b0;
        error_count        = 0;
        quiet_cycles       = 0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        hold_off_left      = 0;

        door_cfg.open_time_ms  = OPEN_TIME_RST;
        door_cfg.hold_time_ms  = HOLD_TIME_RST;
        door_cfg.close_time_ms = CLOSE_TIME_RST;
        door_cfg.drive_duty    = DRIVE_DUTY_RST;
        door_phase_q           = PH_IDLE;
        elapsed_q              = '0;
        free_access_q          = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_zero_times();
        test_free_access();

        write_regs(short_time(), short_time(), short_time(), CFG_DATA_W'($urandom));
        test_random_traffic(150, 6, 78);
        write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        test_random_traffic(30, 78, 6);
        write_regs(short_time(), short_time(), short_time(), CFG_DATA_W'($urandom));
        test_random_traffic(140, 78, 6);
        test_backpressure();
        write_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                   CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        test_random_traffic(20, 0, 0);
        write_regs(short_time(), short_time(), short_time(), CFG_DATA_W'($urandom));
        test_random_traffic(150, 0, 0);

        drain_requests();
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
